@@ sv/mspp_pkg.sv @@
// shared types, constants and the crc-8 step of the msp v2 frame parser
`timescale 1ns / 1ps
package mspp_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned IDX_W           = 6;

  localparam logic [7:0] CRC_POLY   = 8'hD5;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_REQUEST = 8'h3C;

  // frame descriptor handed from the parser to the emitter
  typedef struct packed {
    logic [15:0]      command;
    logic [LEN_W-1:0] length;
  } mspp_desc_t;

  // one result item
  typedef struct packed {
    logic [15:0]      command;
    logic [LEN_W-1:0] length;
    logic             has_data;
    logic [IDX_W-1:0] index;
    logic [7:0]       data;
    logic             last;
  } mspp_item_t;

  // crc-8 dvb-s2, msb first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ sv/mspp_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module mspp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mspp_front.sv @@
// header parser, crc check and payload write side of the frame parser
`timescale 1ns / 1ps
module mspp_front import mspp_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF,
  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    rx_byte_i,
  output logic          full_o,
  input  logic          dq_full_i,
  output logic          ram_we_o,
  output logic [IdxW:0] ram_waddr_o,
  output logic [7:0]    ram_wdata_o,
  output logic          desc_push_o,
  output mspp_desc_t    desc_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_X       = 10'b00_0000_0010,
    S_DIR     = 10'b00_0000_0100,
    S_FLAGS   = 10'b00_0000_1000,
    S_CMD_LO  = 10'b00_0001_0000,
    S_CMD_HI  = 10'b00_0010_0000,
    S_LEN_LO  = 10'b00_0100_0000,
    S_LEN_HI  = 10'b00_1000_0000,
    S_PAYLOAD = 10'b01_0000_0000,
    S_CRC     = 10'b10_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] offset_q, offset_d;
  logic [7:0]       crc_q, crc_d;
  logic [15:0]      cmd_q, cmd_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             bank_q, bank_d;

  logic             accept;
  logic [7:0]       crc_next;
  logic [15:0]      len_full;
  logic [LEN_W-1:0] offset_inc;

  // payload and crc bytes need a free bank / descriptor slot
  assign full_o = dq_full_i && ((state_q == S_PAYLOAD) || (state_q == S_CRC));
  assign accept = push_i && !full_o;

  assign crc_next   = crc8_step(crc_q, rx_byte_i);
  assign len_full   = {rx_byte_i, len_lo_q};
  assign offset_inc = offset_q + LEN_W'(1);

  assign ram_waddr_o = {bank_q, offset_q[IdxW-1:0]};
  assign ram_wdata_o = rx_byte_i;
  assign desc_o      = '{command: cmd_q, length: len_q};

  always_comb begin
    state_d     = state_q;
    offset_d    = offset_q;
    crc_d       = crc_q;
    cmd_d       = cmd_q;
    len_lo_d    = len_lo_q;
    len_d       = len_q;
    bank_d      = bank_q;
    ram_we_o    = 1'b0;
    desc_push_o = 1'b0;
    if (accept) begin
      unique case (state_q)
        S_IDLE: state_d = (rx_byte_i == CH_DOLLAR) ? S_X : S_IDLE;
        S_X:    state_d = (rx_byte_i == CH_X) ? S_DIR : S_IDLE;
        S_DIR:  state_d = (rx_byte_i == CH_REQUEST) ? S_FLAGS : S_IDLE;
        S_FLAGS: begin
          crc_d   = crc8_step(8'h00, rx_byte_i);
          state_d = S_CMD_LO;
        end
        S_CMD_LO: begin
          cmd_d   = {8'h00, rx_byte_i};
          crc_d   = crc_next;
          state_d = S_CMD_HI;
        end
        S_CMD_HI: begin
          cmd_d   = {rx_byte_i, cmd_q[7:0]};
          crc_d   = crc_next;
          state_d = S_LEN_LO;
        end
        S_LEN_LO: begin
          len_lo_d = rx_byte_i;
          crc_d    = crc_next;
          state_d  = S_LEN_HI;
        end
        S_LEN_HI: begin
          len_d = len_full[LEN_W-1:0];
          if (len_full > 16'(MaxPayload)) begin
            state_d  = S_IDLE;
            offset_d = '0;
            crc_d    = '0;
          end else begin
            crc_d   = crc_next;
            state_d = (len_full == 16'd0) ? S_CRC : S_PAYLOAD;
          end
        end
        S_PAYLOAD: begin
          ram_we_o = 1'b1;
          offset_d = offset_inc;
          crc_d    = crc_next;
          if (offset_inc >= len_q) begin
            state_d = S_CRC;
          end
        end
        S_CRC: begin
          // good crc: hand the frame over and switch to the other bank
          if (rx_byte_i == crc_q) begin
            desc_push_o = 1'b1;
            bank_d      = !bank_q;
          end
          state_d  = S_IDLE;
          offset_d = '0;
          crc_d    = '0;
        end
        default: begin
          state_d  = S_IDLE;
          offset_d = '0;
          crc_d    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      offset_q <= '0;
      crc_q    <= '0;
      cmd_q    <= '0;
      len_lo_q <= '0;
      len_q    <= '0;
      bank_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      offset_q <= offset_d;
      crc_q    <= crc_d;
      cmd_q    <= cmd_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      bank_q   <= bank_d;
    end
  end

endmodule

@@ sv/mspp_frame_queue.sv @@
// two-entry queue of accepted frame descriptors, one per payload bank
`timescale 1ns / 1ps
module mspp_frame_queue import mspp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mspp_desc_t desc_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output mspp_desc_t head_o
);

  mspp_desc_t entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ sv/mspp_back.sv @@
// emitter: reads stored payload and delivers result items through a small queue
`timescale 1ns / 1ps
module mspp_back import mspp_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF,
  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  mspp_desc_t    head_i,
  output logic          desc_pop_o,
  output logic          ram_re_o,
  output logic [IdxW:0] ram_raddr_o,
  input  logic [7:0]    ram_rdata_i,
  input  logic          pop_i,
  output logic          empty_o,
  output mspp_item_t    item_o
);

  logic [LEN_W-1:0] idx_q;
  logic             bank_q;
  logic             infl_q;
  mspp_item_t       meta_q;
  mspp_item_t       oq_q [2];
  logic             oq_wptr_q, oq_rptr_q;
  logic [1:0]       oq_count_q;

  logic             pop_fire;
  logic [1:0]       occ;
  logic             issue;
  logic             issue_last;
  logic [LEN_W-1:0] idx_inc;
  mspp_item_t       meta_d;
  mspp_item_t       landed;

  assign empty_o  = (oq_count_q == 2'd0);
  assign item_o   = oq_q[oq_rptr_q];
  assign pop_fire = pop_i && !empty_o;

  // queued items plus the read in flight must fit in two slots
  assign occ   = oq_count_q + 2'(infl_q);
  assign issue = head_valid_i && ((occ < 2'd2) || pop_fire);

  assign idx_inc    = idx_q + LEN_W'(1);
  assign issue_last = (head_i.length == '0) || (idx_inc == head_i.length);

  assign ram_re_o    = issue;
  assign ram_raddr_o = {bank_q, idx_q[IdxW-1:0]};
  assign desc_pop_o  = issue && issue_last;

  always_comb begin
    meta_d          = '0;
    meta_d.command  = head_i.command;
    meta_d.length   = head_i.length;
    meta_d.has_data = (head_i.length != '0);
    meta_d.index    = idx_q[IDX_W-1:0];
    meta_d.last     = issue_last;
  end

  always_comb begin
    landed      = meta_q;
    landed.data = meta_q.has_data ? ram_rdata_i : 8'h00;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      meta_q <= meta_d;
    end
    if (infl_q) begin
      oq_q[oq_wptr_q] <= landed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      bank_q     <= 1'b0;
      infl_q     <= 1'b0;
      oq_wptr_q  <= 1'b0;
      oq_rptr_q  <= 1'b0;
      oq_count_q <= 2'd0;
    end else begin
      infl_q <= issue;
      if (issue) begin
        idx_q <= issue_last ? '0 : idx_inc;
        if (issue_last) begin
          bank_q <= !bank_q;
        end
      end
      if (infl_q) begin
        oq_wptr_q <= !oq_wptr_q;
      end
      if (pop_fire) begin
        oq_rptr_q <= !oq_rptr_q;
      end
      oq_count_q <= oq_count_q + 2'(infl_q) - 2'(pop_fire);
    end
  end

endmodule

@@ sv/msp_v2_frame_parser.sv @@
// top level of the msp v2 request frame parser
// usage:
//   input side is a queue write port: a byte transfers when push is high and
//   full is low; one received serial byte per transfer
//   result side is a queue read port: while empty is low the oldest result is
//   on command_o .. last_o, and it transfers when pop is high
//   a frame with good crc yields one result per payload byte, byte_index
//   counting up and last_o on the final one; a zero-length frame yields a
//   single result with has_data_o low and last_o high
//   header errors, oversize lengths and crc mismatches drop the frame quietly
// timing:
//   the parser takes each byte as it transfers; the results of a frame come
//   after its crc byte and a ram read, then one result per cycle as long
//   as pop stays high (one payload ram read per cycle sets that rate)
//   two payload banks let a second frame arrive while one is emitted; full
//   rises only on payload or crc bytes while both banks still hold frames
// reset: all queues empty, parser idle, no clearing pass needed
// a stalled receiver simply holds results; nothing is lost or repeated
`timescale 1ns / 1ps
module msp_v2_frame_parser import mspp_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       rx_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [15:0]      command_o,
  output logic [LEN_W-1:0] frame_len_o,
  output logic             has_data_o,
  output logic [IDX_W-1:0] byte_index_o,
  output logic [7:0]       data_byte_o,
  output logic             last_o
);

  localparam int unsigned IdxW     = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  // two banks of payload storage, selected by the top address bit
  localparam int unsigned RamDepth = 2 ** (IdxW + 1);

  logic          ram_we;
  logic [IdxW:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [IdxW:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          desc_push;
  mspp_desc_t    desc_in;
  logic          dq_full;
  logic          dq_valid;
  mspp_desc_t    dq_head;
  logic          desc_pop;
  mspp_item_t    item;

  // front: header state machine, crc, payload writes
  mspp_front #(.MaxPayload(MaxPayload)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .dq_full_i   (dq_full),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .desc_push_o (desc_push),
    .desc_o      (desc_in)
  );

  // decoupling between parser and emitter, one slot per bank
  mspp_frame_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (desc_in),
    .pop_i   (desc_pop),
    .full_o  (dq_full),
    .valid_o (dq_valid),
    .head_o  (dq_head)
  );

  mspp_ram #(.Width(8), .Depth(RamDepth)) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // back: walks the head frame and fills the result queue
  mspp_back #(.MaxPayload(MaxPayload)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (dq_valid),
    .head_i       (dq_head),
    .desc_pop_o   (desc_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .pop_i        (pop),
    .empty_o      (empty),
    .item_o       (item)
  );

  assign command_o    = item.command;
  assign frame_len_o  = item.length;
  assign has_data_o   = item.has_data;
  assign byte_index_o = item.index;
  assign data_byte_o  = item.data;
  assign last_o       = item.last;

endmodule

@@ sv/mspp_checker.sv @@
// port-level checks on the result stream of the frame parser, bound to the top
`timescale 1ns / 1ps
module mspp_checker import mspp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [15:0]      command_o,
  input logic [LEN_W-1:0] frame_len_o,
  input logic             has_data_o,
  input logic [IDX_W-1:0] byte_index_o,
  input logic [7:0]       data_byte_o,
  input logic             last_o
);

  // empty frame result has zero length, index and data and closes the frame
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_data_o) |->
      (last_o && frame_len_o == '0 && byte_index_o == '0 && data_byte_o == 8'h00))
    else $error("empty-frame result malformed");

  // data results stay inside the payload
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_data_o) |-> (LEN_W'(byte_index_o) < frame_len_o))
    else $error("byte_index beyond frame length");

  // last flag sits exactly on the final payload byte
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_data_o) |->
      (last_o == (LEN_W'(byte_index_o) + LEN_W'(1) == frame_len_o)))
    else $error("last flag misplaced");

  // within a frame results follow each other with rising index
  a_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) ##1 !empty |->
      (byte_index_o == $past(byte_index_o) + IDX_W'(1) && command_o == $past(command_o)))
    else $error("frame results out of order");

endmodule

bind msp_v2_frame_parser mspp_checker u_mspp_checker (.*);
